// ===== rtl/core/lcg_pkg.sv =====
package lcg_pkg;

  // APB register file geometry: four 64-bit registers at 8-byte spacing
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned NUM_SYM    = 16;
  localparam int unsigned SIDX_W     = 4;

  typedef enum logic [1:0] {
    REG_SYMBOLS_LOW  = 2'd0,
    REG_SYMBOLS_HIGH = 2'd1,
    REG_SET_SIZE     = 2'd2,
    REG_PICK_COUNT   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_EXHAUST
  } lcg_state_e;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [NUM_SYM*SYM_W-1:0] symbols;
    logic [CNT_W-1:0]         set_size;
    logic [CNT_W-1:0]         pick_count;
    logic                     restart;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // load scan index with k-1, clear emit index
    logic scan_dec;  // step scan index down
    logic scan_end;  // capture pivot and more flag
    logic rd_scan;   // position read uses scan index
    logic emit;      // load one symbol item, advance positions
    logic emit_exh;  // load the exhausted item
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;         // position at scan index can still grow
    logic d_zero;      // scan index at position 0
    logic i_last;      // emit index at k-1
    logic out_free;    // output register can take an item
    logic comb_valid;  // a combination is available
  } stat_t;

endpackage

// ===== rtl/core/lcg_regs.sv =====
module lcg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lcg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lcg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output lcg_pkg::cfg_t                   cfg_o
);

  logic [lcg_pkg::APB_DATA_W-1:0] sym_lo_q, sym_hi_q;
  logic [lcg_pkg::CNT_W-1:0]      set_size_q, pick_count_q;
  logic                           wr;
  lcg_pkg::reg_idx_e              idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = lcg_pkg::reg_idx_e'(paddr[lcg_pkg::APB_ADDR_W-1:3]);
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_lo_q     <= '0;
      sym_hi_q     <= '0;
      set_size_q   <= lcg_pkg::CNT_W'(1);
      pick_count_q <= lcg_pkg::CNT_W'(1);
    end else if (wr) begin
      case (idx)
        lcg_pkg::REG_SYMBOLS_LOW:  sym_lo_q     <= pwdata;
        lcg_pkg::REG_SYMBOLS_HIGH: sym_hi_q     <= pwdata;
        lcg_pkg::REG_SET_SIZE:     set_size_q   <= pwdata[lcg_pkg::CNT_W-1:0];
        lcg_pkg::REG_PICK_COUNT:   pick_count_q <= pwdata[lcg_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      lcg_pkg::REG_SYMBOLS_LOW:  prdata = sym_lo_q;
      lcg_pkg::REG_SYMBOLS_HIGH: prdata = sym_hi_q;
      lcg_pkg::REG_SET_SIZE:     prdata = lcg_pkg::APB_DATA_W'(set_size_q);
      lcg_pkg::REG_PICK_COUNT:   prdata = lcg_pkg::APB_DATA_W'(pick_count_q);
      default:                   prdata = '0;
    endcase
  end

  // Any write restarts the enumeration at the same edge as the register update
  assign cfg_o.symbols    = {sym_hi_q, sym_lo_q};
  assign cfg_o.set_size   = set_size_q;
  assign cfg_o.pick_count = pick_count_q;
  assign cfg_o.restart    = wr;

endmodule

// ===== rtl/core/lcg_ctrl.sv =====
module lcg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           next_request_i,
  output logic           in_stall_o,
  input  lcg_pkg::stat_t stat_i,
  output lcg_pkg::cmd_t  cmd_o
);

  lcg_pkg::lcg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcg_pkg::ST_IDLE: begin
        if (in_valid_i && next_request_i) begin
          state_d = stat_i.comb_valid ? lcg_pkg::ST_SCAN : lcg_pkg::ST_EXHAUST;
        end
      end
      lcg_pkg::ST_SCAN: begin
        if (stat_i.hit || stat_i.d_zero) begin
          state_d = lcg_pkg::ST_EMIT;
        end
      end
      lcg_pkg::ST_EMIT: begin
        if (stat_i.out_free && stat_i.i_last) begin
          state_d = lcg_pkg::ST_IDLE;
        end
      end
      lcg_pkg::ST_EXHAUST: begin
        if (stat_i.out_free) begin
          state_d = lcg_pkg::ST_IDLE;
        end
      end
      default: state_d = lcg_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      lcg_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.start = in_valid_i & next_request_i & stat_i.comb_valid;
      end
      lcg_pkg::ST_SCAN: begin
        cmd_o.rd_scan  = 1'b1;
        cmd_o.scan_end = stat_i.hit | stat_i.d_zero;
        cmd_o.scan_dec = ~(stat_i.hit | stat_i.d_zero);
      end
      lcg_pkg::ST_EMIT: begin
        cmd_o.emit = stat_i.out_free;
      end
      lcg_pkg::ST_EXHAUST: begin
        cmd_o.emit_exh = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/lcg_dp.sv =====
module lcg_dp #(
  parameter int unsigned MAX_SET = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lcg_pkg::cfg_t                  cfg_i,
  input  lcg_pkg::cmd_t                  cmd_i,
  output lcg_pkg::stat_t                 stat_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lcg_pkg::SYM_W-1:0]      symbol_o,
  output logic [lcg_pkg::SIDX_W-1:0]     symbol_index_o,
  output logic                           last_o,
  output logic                           more_after_o,
  output logic                           exhausted_o
);

  localparam int unsigned IW = $clog2(MAX_SET);
  localparam logic [lcg_pkg::CNT_W-1:0] MaxN = lcg_pkg::CNT_W'(MAX_SET);

  logic [IW-1:0]             pos_q [MAX_SET];
  logic [IW-1:0]             d_q, i_q, pivot_q, prev_q;
  logic                      more_q, exh_q;
  logic [lcg_pkg::CNT_W-1:0] n_eff, k, limit;
  logic [IW-1:0]             rd_addr, rd_pos, new_pos;
  logic                      upd;

  // Effective set size and pick count
  assign n_eff = (cfg_i.set_size > MaxN) ? MaxN : cfg_i.set_size;
  assign k     = cfg_i.pick_count;

  // Single read port into the position registers
  assign rd_addr = cmd_i.rd_scan ? d_q : i_q;
  assign rd_pos  = pos_q[rd_addr];

  // Position at scan index may grow while below n-k+d
  assign limit = n_eff - k + lcg_pkg::CNT_W'(d_q);

  assign stat_o.hit        = lcg_pkg::CNT_W'(rd_pos) < limit;
  assign stat_o.d_zero     = (d_q == '0);
  assign stat_o.i_last     = (lcg_pkg::CNT_W'(i_q) == k - lcg_pkg::CNT_W'(1));
  assign stat_o.out_free   = ~out_valid_o | ~out_stall_i;
  assign stat_o.comb_valid = ~exh_q & (k != '0) & (k <= n_eff);

  // Pivot is incremented, later positions refill one past the previous
  assign upd     = more_q && (i_q >= pivot_q);
  assign new_pos = (i_q == pivot_q) ? rd_pos + IW'(1) : prev_q + IW'(1);

  // Position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_SET; j++) begin
        pos_q[j] <= IW'(j);
      end
    end else if (cfg_i.restart) begin
      for (int j = 0; j < MAX_SET; j++) begin
        pos_q[j] <= IW'(j);
      end
    end else if (cmd_i.emit && upd) begin
      pos_q[i_q] <= new_pos;
    end
  end

  // Scan and emit counters, pivot and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q     <= '0;
      i_q     <= '0;
      pivot_q <= '0;
      prev_q  <= '0;
      more_q  <= 1'b0;
      exh_q   <= 1'b0;
    end else begin
      if (cfg_i.restart) begin
        exh_q <= 1'b0;
      end
      if (cmd_i.start) begin
        d_q <= IW'(k - lcg_pkg::CNT_W'(1));
        i_q <= '0;
      end
      if (cmd_i.scan_dec) begin
        d_q <= d_q - IW'(1);
      end
      if (cmd_i.scan_end) begin
        more_q  <= stat_o.hit;
        pivot_q <= d_q;
        if (!stat_o.hit) begin
          exh_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        i_q <= i_q + IW'(1);
        if (upd) begin
          prev_q <= new_pos;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_exh) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      symbol_o       <= cfg_i.symbols[lcg_pkg::SYM_W*lcg_pkg::SIDX_W'(rd_pos) +:
                                      lcg_pkg::SYM_W];
      symbol_index_o <= lcg_pkg::SIDX_W'(rd_pos);
      last_o         <= stat_o.i_last;
      more_after_o   <= more_q;
      exhausted_o    <= 1'b0;
    end else if (cmd_i.emit_exh) begin
      symbol_o       <= '0;
      symbol_index_o <= '0;
      last_o         <= 1'b1;
      more_after_o   <= 1'b0;
      exhausted_o    <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/lexicographic_combination_generator.sv =====
// Lexicographic k-combination generator.
// A request with k picks first scans positions downward from index k-1 for the carry,
// then emits one item per cycle while the output register is not stalled.
// No new request is accepted until the last item of the current one has been loaded
// into the output register.
// Reset (async, active low): registers to symbols 0, set size 1, pick count 1.
module lexicographic_combination_generator #(
  parameter int unsigned MAX_SET = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lcg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lcg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lcg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            next_request_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lcg_pkg::SYM_W-1:0]       symbol_o,
  output logic [lcg_pkg::SIDX_W-1:0]      symbol_index_o,
  output logic                            last_o,
  output logic                            more_after_o,
  output logic                            exhausted_o
);

  lcg_pkg::cfg_t  cfg;
  lcg_pkg::cmd_t  cmd;
  lcg_pkg::stat_t stat;

  lcg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcg_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .next_request_i (next_request_i),
    .in_stall_o     (in_stall_o),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  lcg_dp #(
    .MAX_SET (MAX_SET)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .symbol_index_o (symbol_index_o),
    .last_o         (last_o),
    .more_after_o   (more_after_o),
    .exhausted_o    (exhausted_o)
  );

endmodule

// ===== rtl/core/lcg_checker.sv =====
module lcg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        next_request_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lcg_pkg::SYM_W-1:0]   symbol_o,
  input logic [lcg_pkg::SIDX_W-1:0]  symbol_index_o,
  input logic                        last_o,
  input logic                        more_after_o,
  input logic                        exhausted_o
);

  // Stalled item stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped under stall");

  // Stalled item payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(symbol_o) && $stable(symbol_index_o) &&
      $stable(last_o) && $stable(more_after_o) && $stable(exhausted_o))
    else $error("output payload changed under stall");

  // Exhausted item is a lone, empty, final item
  a_exh_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exhausted_o |-> last_o && !more_after_o && symbol_o == '0 &&
      symbol_index_o == '0)
    else $error("malformed exhausted item");

  // An accepted request makes the block busy in the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && next_request_i |=> in_stall_o)
    else $error("request accepted without going busy");

endmodule

bind lexicographic_combination_generator lcg_checker u_lcg_checker (.*);
